// ----- rtl/ksel_pkg.sv -----
// Shared widths, defaults and the beat type that travels along the cell row.
`default_nettype none
package ksel_pkg;

  localparam int MaxItemsDef = 1024;
  localparam int KeyW        = 32;
  localparam int RankW       = 11;
  localparam int StatusW     = 2;

  typedef struct packed {
    logic              vld;
    logic signed [KeyW-1:0] key;
  } wave_t;

endpackage
`default_nettype wire

// ----- rtl/ksel_cell.sv -----
// One cell of the insertion chain: keeps one key, passes the larger one on.
`default_nettype none
module ksel_cell
  import ksel_pkg::*;
#(
  parameter int CntW = 11,
  parameter int Idx  = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wave_t                  wave_i,
  input  wire logic [CntW-1:0]        tag_i,
  input  wire logic                   shift_i,
  input  wire logic signed [KeyW-1:0] nbr_key_i,
  output wave_t                       wave_o,
  output logic [CntW-1:0]             tag_o,
  output logic signed [KeyW-1:0]      key_o
);

  localparam logic [CntW-1:0] IdxL = CntW'(Idx);

  logic signed [KeyW-1:0] key_d, key_q;
  logic                   vld_d, vld_q;
  logic signed [KeyW-1:0] pkey_d, pkey_q;
  logic [CntW-1:0]        tag_d, tag_q;

  always_comb begin
    key_d  = key_q;
    vld_d  = 1'b0;
    pkey_d = wave_i.key;
    tag_d  = tag_i;
    if (shift_i) begin
      key_d = nbr_key_i;
    end else if (wave_i.vld) begin
      if (tag_i == IdxL) begin
        // first free slot: the beat settles here
        key_d = wave_i.key;
      end else if ($signed(wave_i.key) < key_q) begin
        key_d  = wave_i.key;
        vld_d  = 1'b1;
        pkey_d = key_q;
      end else begin
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pkey_q <= pkey_d;
    tag_q  <= tag_d;
  end

  assign wave_o = '{vld: vld_q, key: pkey_q};
  assign tag_o  = tag_q;
  assign key_o  = key_q;

endmodule
`default_nettype wire

// ----- rtl/kth_smallest_select.sv -----
// Loading: one beat per cycle; the row of cells sorts as beats stream in.
// After the last beat: the settle state lets the row of cells settle, then the
// shift state moves the keys k-1 places toward cell 0 (k = rank), then the emit
// state loads the output register once it is free.
// Rank error or overflow: no sort; the emit state follows the last beat directly.
// Input is held off from the last beat until the result is registered.
// Reset: rank 1, store empty, overflow clear; cell contents are not reset.
`default_nettype none
module kth_smallest_select
  import ksel_pkg::*;
#(
  parameter int MAX_ITEMS = MaxItemsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] kth_value, [33:32] status
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);
  localparam int TmW  = (CntW > RankW) ? CntW : RankW;

  localparam logic [StatusW-1:0] StOk   = 2'd0;
  localparam logic [StatusW-1:0] StRank = 2'd1;
  localparam logic [StatusW-1:0] StOvf  = 2'd2;

  localparam logic RegRank = 1'b0;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSettle = 4'b0010,
    StShift  = 4'b0100,
    StEmit   = 4'b1000
  } state_e;

  state_e state_d, state_q;

  logic [RankW-1:0]   rank_d, rank_q;
  logic [CntW-1:0]    count_d, count_q;
  logic               ovf_d, ovf_q;
  logic [TmW-1:0]     tm_d, tm_q;
  logic [StatusW-1:0] status_d, status_q;
  wave_t              in_wave_d, in_wave_q;
  logic [CntW-1:0]    in_tag_d, in_tag_q;
  logic               out_vld_d, out_vld_q;
  logic [KeyW-1:0]    out_kth_d, out_kth_q;
  logic [StatusW-1:0] out_st_d, out_st_q;

  logic               acc, stored, shift_en, cfg_wr;
  logic [CntW-1:0]    count_new;
  logic               ovf_new;

  wave_t                  waves [MAX_ITEMS+1];
  logic [CntW-1:0]        tags  [MAX_ITEMS+1];
  logic signed [KeyW-1:0] keys  [MAX_ITEMS];

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;
  assign prdata_o = (paddr_i[2] == RegRank) ? 32'(rank_q) : 32'd0;

  always_comb begin
    rank_d = rank_q;
    if (cfg_wr && paddr_i[2] == RegRank) begin
      rank_d = pwdata_i[RankW-1:0];
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign acc       = s_axis_tvalid_i & s_axis_tready_o;
  assign stored    = (count_q != CntW'(MAX_ITEMS));
  assign count_new = stored ? count_q + CntW'(1) : count_q;
  assign ovf_new   = ovf_q | ~stored;
  assign shift_en  = (state_q == StShift) && (tm_q != '0);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    tm_d      = tm_q;
    status_d  = status_q;
    in_wave_d = '{vld: 1'b0, key: $signed(s_axis_tdata_i)};
    in_tag_d  = count_q;
    out_vld_d = out_vld_q & ~m_axis_tready_i;
    out_kth_d = out_kth_q;
    out_st_d  = out_st_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          in_wave_d.vld = stored;
          count_d       = count_new;
          ovf_d         = ovf_new;
          if (s_axis_tlast_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
            if (ovf_new) begin
              status_d = StOvf;
              state_d  = StEmit;
            end else if (rank_q == '0 || TmW'(rank_q) > TmW'(count_new)) begin
              status_d = StRank;
              state_d  = StEmit;
            end else begin
              status_d = StOk;
              tm_d     = TmW'(count_new);
              state_d  = StSettle;
            end
          end
        end
      end
      StSettle: begin
        if (tm_q == '0) begin
          tm_d    = TmW'(rank_q - RankW'(1));
          state_d = StShift;
        end else begin
          tm_d = tm_q - TmW'(1);
        end
      end
      StShift: begin
        if (tm_q == '0) begin
          state_d = StEmit;
        end else begin
          tm_d = tm_q - TmW'(1);
        end
      end
      StEmit: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_kth_d = (status_q == StOk) ? keys[0] : '0;
          out_st_d  = status_q;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rank_q    <= RankW'(1);
      count_q   <= '0;
      ovf_q     <= 1'b0;
      tm_q      <= '0;
      in_wave_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rank_q    <= rank_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      tm_q      <= tm_d;
      in_wave_q <= in_wave_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    in_tag_q  <= in_tag_d;
    out_kth_q <= out_kth_d;
    out_st_q  <= out_st_d;
  end

  assign waves[0] = in_wave_q;
  assign tags[0]  = in_tag_q;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ksel_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wave_i    (waves[i]),
      .tag_i     (tags[i]),
      .shift_i   (shift_en),
      .nbr_key_i ((i == MAX_ITEMS - 1) ? keys[i] : keys[(i + 1) % MAX_ITEMS]),
      .wave_o    (waves[i+1]),
      .tag_o     (tags[i+1]),
      .key_o     (keys[i])
    );
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_st_q, out_kth_q};

`ifndef SYNTH
  a_no_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(waves[MAX_ITEMS].vld && tags[MAX_ITEMS] >= CntW'(MAX_ITEMS)) && !waves[MAX_ITEMS].vld)
    else $error("beat ran off the end of the cell row");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q != StOk) |-> (out_kth_q == '0))
    else $error("nonzero value with error status");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSettle || state_q == StShift) |-> !in_wave_d.vld)
    else $error("beat loaded while sorting");
`endif

endmodule
`default_nettype wire
